>>> design/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// shared constants, decode helper and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

    // storage and output limits
    localparam int SYSEX_DEPTH_DEF = 64;
    localparam int MAX_RESULTS     = 64;

    // byte codes
    localparam logic [7:0] B_RT_MIN      = 8'hF8;
    localparam logic [7:0] B_SX_START    = 8'hF0;
    localparam logic [7:0] B_SX_END      = 8'hF7;
    localparam logic [7:0] B_SYS_COMMON  = 8'hF0;
    localparam logic [7:0] B_NOTE_MIN    = 8'h80;
    localparam logic [7:0] B_NOTE_MAX    = 8'hBF;
    localparam logic [7:0] B_PROG_MIN    = 8'hC0;
    localparam logic [7:0] B_PROG_MAX    = 8'hDF;
    localparam logic [7:0] B_BEND_MIN    = 8'hE0;
    localparam logic [7:0] B_BEND_MAX    = 8'hEF;
    localparam logic [7:0] B_MTC_QF      = 8'hF1;
    localparam logic [7:0] B_SONG_SEL    = 8'hF3;
    localparam logic [7:0] B_SONG_POS    = 8'hF2;

    // number of data bytes a status byte takes
    function automatic logic [1:0] needed_data(input logic [7:0] s);
        logic [1:0] n;
        n = 2'd0;
        if (s inside {[B_NOTE_MIN:B_NOTE_MAX]}) begin
            n = 2'd2;
        end else if (s inside {[B_PROG_MIN:B_PROG_MAX]}) begin
            n = 2'd1;
        end else if (s inside {[B_BEND_MIN:B_BEND_MAX]}) begin
            n = 2'd2;
        end else if (s == B_MTC_QF || s == B_SONG_SEL) begin
            n = 2'd1;
        end else if (s == B_SONG_POS) begin
            n = 2'd2;
        end
        return n;
    endfunction

    // controller to datapath
    typedef struct packed {
        logic accept;    // take the input byte and update the parser
        logic msg_next;  // move the next data byte of a message out
        logic sx_read;   // first read of the sysex buffer
        logic sx_load;   // move a buffered sysex byte out, prefetch the next
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic slot_free; // output register empty or being drained
        logic msg_cont;  // input byte completes a message with data bytes
        logic sx_end;    // input byte closes an open sysex
        logic msg_last;  // current message byte is the final one
        logic sx_last;   // current sysex byte is the final one
    } t_status;

endpackage

`default_nettype wire

>>> design/msp_ctrl.sv
// ----------------------------------------------------------------------------
// msp_ctrl
// sequencing of byte intake, message emission and sysex drain
// ----------------------------------------------------------------------------
`default_nettype none

module msp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire msp_pkg::t_status i_st,
    output msp_pkg::t_cmd         o_cmd
);
    import msp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_MSG     = 4'b0010,
        ST_SX_READ = 4'b0100,
        ST_SX_LOAD = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = i_st.slot_free;
                o_cmd.accept = i_in_valid && i_st.slot_free;
                if (o_cmd.accept) begin
                    if (i_st.msg_cont) begin
                        n_state = ST_MSG;
                    end else if (i_st.sx_end) begin
                        n_state = ST_SX_READ;
                    end
                end
            end
            ST_MSG: begin
                if (i_st.slot_free) begin
                    o_cmd.msg_next = 1'b1;
                    if (i_st.msg_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SX_READ: begin
                o_cmd.sx_read = 1'b1;
                n_state       = ST_SX_LOAD;
            end
            ST_SX_LOAD: begin
                if (i_st.slot_free) begin
                    o_cmd.sx_load = 1'b1;
                    if (i_st.sx_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> design/msp_dpath.sv
// ----------------------------------------------------------------------------
// msp_dpath
// parser state, sysex buffer and output register
// ----------------------------------------------------------------------------
`default_nettype none

module msp_dpath #(
    parameter int SYSEX_DEPTH = msp_pkg::SYSEX_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [7:0]       i_in_byte,
    input  wire logic             i_out_ready,
    input  wire msp_pkg::t_cmd    i_cmd,
    output msp_pkg::t_status      o_st,
    output logic                  o_out_valid,
    output logic [7:0]            o_out_byte,
    output logic                  o_last
);
    import msp_pkg::*;

    localparam int AW = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;
    localparam int FW = $clog2(SYSEX_DEPTH + 1);

    // parser state
    logic [7:0]    r_running;
    logic [7:0]    r_cur;
    logic [6:0]    r_data [2];
    logic [1:0]    r_count;
    logic [1:0]    r_expected;
    logic          r_active;
    logic          r_sx_open;
    logic [FW-1:0] r_fill;

    // emission
    logic [1:0]    r_msg_idx;
    logic [AW-1:0] r_rd_idx;
    logic [AW-1:0] r_sx_last;
    logic [7:0]    r_rd_data;
    logic [7:0]    r_mem [SYSEX_DEPTH];
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    // decode
    logic          is_rt;
    logic          is_status;
    logic          is_sx_start;
    logic          is_sx_end;
    logic [1:0]    needed_b;
    logic [7:0]    eff_status;
    logic [1:0]    eff_count;
    logic [1:0]    eff_exp;
    logic [1:0]    cnt1;
    logic          data_go;
    logic          data_done;
    logic          store_room;
    logic [FW-1:0] fill_inc;
    logic [FW-1:0] fill_end;
    logic [AW-1:0] sx_last_n;

    // output load
    logic          load;
    logic [7:0]    load_byte;
    logic          load_last;

    // buffer ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    always_comb begin
        is_rt       = (i_in_byte >= B_RT_MIN);
        is_status   = i_in_byte[7];
        is_sx_start = (i_in_byte == B_SX_START);
        is_sx_end   = (i_in_byte == B_SX_END);
        needed_b    = needed_data(i_in_byte);

        // running status opens a fresh message
        eff_status  = r_active ? r_cur      : r_running;
        eff_count   = r_active ? r_count    : 2'd0;
        eff_exp     = r_active ? r_expected : needed_data(r_running);
        cnt1        = eff_count + 2'd1;
        data_go     = !is_status && !r_sx_open && (r_active || (r_running != 8'h00));
        data_done   = data_go && (cnt1 >= eff_exp);

        store_room  = (r_fill < FW'(SYSEX_DEPTH));
        fill_inc    = r_fill + FW'(1);
        fill_end    = store_room ? fill_inc : r_fill;
        sx_last_n   = (32'(fill_end) > 32'(MAX_RESULTS)) ? AW'(MAX_RESULTS - 1)
                                                         : AW'(fill_end - FW'(1));
    end

    always_comb begin
        load      = 1'b0;
        load_byte = i_in_byte;
        load_last = 1'b1;
        if (i_cmd.accept) begin
            if (is_rt) begin
                load = 1'b1;
            end else if (is_status && !is_sx_start && !is_sx_end && (needed_b == 2'd0)) begin
                load = 1'b1;
            end else if (data_done) begin
                load      = 1'b1;
                load_byte = eff_status;
                load_last = (eff_exp == 2'd0);
            end
        end else if (i_cmd.msg_next) begin
            load      = 1'b1;
            load_byte = {1'b0, r_data[r_msg_idx[1]]};
            load_last = (r_msg_idx == r_expected);
        end else if (i_cmd.sx_load) begin
            load      = 1'b1;
            load_byte = r_rd_data;
            load_last = (r_rd_idx == r_sx_last);
        end
    end

    always_comb begin
        wr_en   = i_cmd.accept && (is_sx_start ||
                  ((is_sx_end || !is_status) && r_sx_open && store_room));
        wr_addr = is_sx_start ? '0 : r_fill[AW-1:0];
        rd_en   = i_cmd.sx_read || (i_cmd.sx_load && (r_rd_idx != r_sx_last));
        rd_addr = i_cmd.sx_load ? AW'(r_rd_idx + AW'(1)) : r_rd_idx;
    end

    // sysex buffer, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_in_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // parser control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 8'h00;
            r_cur      <= 8'h00;
            r_count    <= 2'd0;
            r_expected <= 2'd0;
            r_active   <= 1'b0;
            r_sx_open  <= 1'b0;
            r_fill     <= '0;
        end else if (i_cmd.accept && !is_rt) begin
            if (is_sx_start) begin
                r_sx_open <= 1'b1;
                r_fill    <= FW'(1);
                r_running <= 8'h00;
                r_active  <= 1'b0;
            end else if (is_sx_end) begin
                r_sx_open <= 1'b0;
                r_fill    <= '0;
                r_running <= 8'h00;
                r_active  <= 1'b0;
            end else if (is_status) begin
                r_sx_open  <= 1'b0;
                r_fill     <= '0;
                r_cur      <= i_in_byte;
                r_count    <= 2'd0;
                r_expected <= needed_b;
                r_active   <= (needed_b != 2'd0) || (i_in_byte < B_SYS_COMMON);
                r_running  <= (i_in_byte < B_SYS_COMMON) ? i_in_byte : 8'h00;
            end else if (r_sx_open) begin
                if (store_room) begin
                    r_fill <= fill_inc;
                end
            end else if (data_go) begin
                r_cur      <= eff_status;
                r_expected <= eff_exp;
                if (data_done) begin
                    r_count  <= 2'd0;
                    r_active <= (r_running != 8'h00);
                end else begin
                    r_count  <= cnt1;
                    r_active <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && data_go) begin
            r_data[eff_count[0]] <= i_in_byte[6:0];
        end
        if (i_cmd.accept && data_done) begin
            r_msg_idx <= 2'd1;
        end else if (i_cmd.msg_next) begin
            r_msg_idx <= r_msg_idx + 2'd1;
        end
        if (i_cmd.accept && is_sx_end && r_sx_open) begin
            r_rd_idx  <= '0;
            r_sx_last <= sx_last_n;
        end else if (i_cmd.sx_load && (r_rd_idx != r_sx_last)) begin
            r_rd_idx <= AW'(r_rd_idx + AW'(1));
        end
        if (load) begin
            r_out_byte <= load_byte;
            r_out_last <= load_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_st.slot_free = !r_out_valid || i_out_ready;
        o_st.msg_cont  = data_done && (eff_exp != 2'd0);
        o_st.sx_end    = is_sx_end && r_sx_open;
        o_st.msg_last  = (r_msg_idx == r_expected);
        o_st.sx_last   = (r_rd_idx == r_sx_last);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

>>> design/midi_stream_message_parser_unit.sv
// ----------------------------------------------------------------------------
// midi_stream_message_parser_unit
// midi byte stream parser with running status and buffered sysex
// ----------------------------------------------------------------------------
//
//  channel | signals                              | moves
//  --------+--------------------------------------+---------------------------
//  input   | i_in_valid, o_in_ready, i_in_byte    | one raw midi byte
//  output  | o_out_valid, i_out_ready, o_out_byte,| one message byte, o_last
//          | o_last                               | on the final byte
//
//  one input byte a cycle while the output register is free or being taken
//  a completed channel or common message holds the input while its data bytes
//  (at most two) follow the status byte out
//  a closing f7 holds the input while the buffered sysex, at most 64 bytes,
//  drains: one buffer read to prime the read register, then one buffered
//  byte a cycle while the output is free; output stalls hold the input;
//  reset is synchronous, active low, and needs no clearing pass since only
//  bytes written in the current sysex are read
`default_nettype none

module midi_stream_message_parser_unit #(
    parameter int SYSEX_DEPTH = msp_pkg::SYSEX_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last
);
    import msp_pkg::*;

    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status st;

    // sequencer: idle intake, message data emission, sysex drain
    msp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // datapath: running status, data byte capture, sysex buffer and the
    // output register; intake continues only while it is empty or being taken
    msp_dpath #(
        .SYSEX_DEPTH (SYSEX_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_byte   (i_in_byte),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

>>> design/msp_checker.sv
// ----------------------------------------------------------------------------
// msp_checker
// port level checks for the midi stream parser
// ----------------------------------------------------------------------------
`default_nettype none

module msp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic [7:0] i_in_byte,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_last
);
    import msp_pkg::*;

    // held output transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte) && $stable(o_last))
        else $error("output transaction changed while stalled");

    // real-time bytes come out alone in the next cycle
    a_rt_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_byte >= B_RT_MIN)
        |=> o_out_valid && o_last && (o_out_byte == $past(i_in_byte)))
        else $error("real-time byte not passed through");

    // a data byte can only start a message with its status byte
    a_data_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in_byte[7]
        |=> !o_out_valid || (o_out_byte[7] && !o_last))
        else $error("data byte produced a bad message head");

    // sysex start produces nothing
    a_sx_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_byte == B_SX_START) |=> !o_out_valid)
        else $error("sysex start produced output");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind midi_stream_message_parser_unit msp_checker u_msp_checker (.*);

`default_nettype wire
